>>> design/trlc_pkg.sv
package trlc_pkg;

  localparam int LETTER_COUNT = 26;

  typedef logic [4:0] letter_t;
  typedef letter_t rotor_table_t [LETTER_COUNT];

  localparam letter_t LAST_LETTER = letter_t'(LETTER_COUNT - 1);

  // forward rotor wirings
  localparam rotor_table_t FWD_A = '{
    5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19, 5'd14,
    5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17, 5'd2, 5'd9};
  localparam rotor_table_t FWD_B = '{
    5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7, 5'd22,
    5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21, 5'd14, 5'd4};
  localparam rotor_table_t FWD_C = '{
    5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21, 5'd25,
    5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18, 5'd16, 5'd14};

  localparam rotor_table_t REFLECTOR = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6, 5'd14,
    5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9, 5'd0, 5'd19};

  // return-path wirings
  localparam rotor_table_t BACK_A = '{
    5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4, 5'd2,
    5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16, 5'd14, 5'd9};
  localparam rotor_table_t BACK_B = '{
    5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10, 5'd14,
    5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8, 5'd21, 5'd18};
  localparam rotor_table_t BACK_C = '{
    5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5, 5'd21,
    5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10, 5'd14, 5'd12};

  // (a + b) mod 26, both operands already below 26
  function automatic letter_t add_mod(letter_t a, letter_t b);
    logic [5:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= 6'(LETTER_COUNT)) begin
      sum = sum - 6'(LETTER_COUNT);
    end
    return sum[4:0];
  endfunction

  // (a - b) mod 26, both operands already below 26
  function automatic letter_t sub_mod(letter_t a, letter_t b);
    logic [5:0] diff;
    diff = {1'b0, a} + 6'(LETTER_COUNT) - {1'b0, b};
    if (diff >= 6'(LETTER_COUNT)) begin
      diff = diff - 6'(LETTER_COUNT);
    end
    return diff[4:0];
  endfunction

  // codes 26..31 fold back onto 0..5
  function automatic letter_t fold_letter(letter_t a);
    return (a >= letter_t'(LETTER_COUNT)) ? letter_t'(a - letter_t'(LETTER_COUNT)) : a;
  endfunction

endpackage

>>> design/trlc_if.sv
interface plain_if;
  import trlc_pkg::*;
  logic    valid;
  logic    ready;
  letter_t plain_letter;
  modport source (output valid, output plain_letter, input ready);
  modport sink (input valid, input plain_letter, output ready);
endinterface

interface cipher_if;
  import trlc_pkg::*;
  logic    valid;
  logic    ready;
  letter_t cipher_letter;
  modport source (output valid, output cipher_letter, input ready);
  modport sink (input valid, input cipher_letter, output ready);
endinterface

>>> design/three_rotor_letter_cipher.sv
// Three-rotor letter cipher with a fixed reflector. Each item on plain carries one letter
// (0 = a .. 25 = z) and yields one item on cipher. One letter is taken every clock cycle
// when the output side keeps up; a result passes through the stage register and then the
// result register before it shows on cipher. The cycle time is set by the chain of seven
// table lookups and mod-26 adds between those two registers. Rotor positions reset
// to zero and step like a base-26 odometer on every accepted letter, the fast rotor first.
// Letter codes 26..31 act as code minus 26. Back-pressure on cipher stalls both stages.
module three_rotor_letter_cipher
  import trlc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  plain_if.sink    plain,
  cipher_if.source cipher
);

  // rotor positions, always kept in 0..25
  letter_t fast_position;
  letter_t middle_position;
  letter_t slow_position;
  letter_t fast_position_next;
  letter_t middle_position_next;
  letter_t slow_position_next;

  // stage register: letter plus the positions it is enciphered with
  logic    stage_valid;
  letter_t stage_letter;
  letter_t stage_fast;
  letter_t stage_middle;
  letter_t stage_slow;

  // result register
  logic    out_valid;
  letter_t out_letter;

  logic    accept;
  logic    out_load;
  letter_t cipher_next;

  // result register is free, or being emptied this cycle
  assign out_load     = stage_valid && (!out_valid || cipher.ready);
  assign plain.ready  = !stage_valid || out_load;
  assign accept       = plain.valid && plain.ready;

  assign cipher.valid         = out_valid;
  assign cipher.cipher_letter = out_letter;

  // odometer stepping
  always_comb begin
    fast_position_next   = fast_position + letter_t'(1);
    middle_position_next = middle_position;
    slow_position_next   = slow_position;
    if (fast_position == LAST_LETTER) begin
      fast_position_next   = '0;
      middle_position_next = middle_position + letter_t'(1);
      if (middle_position == LAST_LETTER) begin
        middle_position_next = '0;
        slow_position_next   = (slow_position == LAST_LETTER) ? '0
                             : slow_position + letter_t'(1);
      end
    end
  end

  // signal path: three rotors forward, reflector, three rotors back
  always_comb begin
    letter_t c;
    c = FWD_A[add_mod(fold_letter(stage_letter), stage_fast)];
    c = FWD_B[add_mod(c, stage_middle)];
    c = FWD_C[add_mod(c, stage_slow)];
    c = REFLECTOR[c];
    c = sub_mod(BACK_C[c], stage_slow);
    c = sub_mod(BACK_B[c], stage_middle);
    c = sub_mod(BACK_A[c], stage_fast);
    cipher_next = c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_position   <= '0;
      middle_position <= '0;
      slow_position   <= '0;
      stage_valid     <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        fast_position   <= fast_position_next;
        middle_position <= middle_position_next;
        slow_position   <= slow_position_next;
        stage_valid     <= 1'b1;
      end else if (out_load) begin
        stage_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (cipher.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_letter <= plain.plain_letter;
      stage_fast   <= fast_position;
      stage_middle <= middle_position;
      stage_slow   <= slow_position;
    end
    if (out_load) begin
      out_letter <= cipher_next;
    end
  end

endmodule

>>> design/trlc_checker.sv
module trlc_checker
  import trlc_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    plain_valid,
  input logic    plain_ready,
  input letter_t plain_letter,
  input logic    cipher_valid,
  input logic    cipher_ready,
  input letter_t cipher_letter
);

  logic plain_take;
  assign plain_take = plain_valid && plain_ready;

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !cipher_valid)
    else $error("cipher item present right after reset");

  // every result is a real letter
  a_letter_range: assert property (@(posedge clk) disable iff (rst)
    cipher_valid |-> (cipher_letter < letter_t'(LETTER_COUNT)))
    else $error("cipher letter out of range");

  // a fresh result follows an accepted item through the stage and result registers
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(cipher_valid) |-> $past(plain_take, 2))
    else $error("cipher item without an accepted letter");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    cipher_valid && !cipher_ready |=> cipher_valid && $stable(cipher_letter))
    else $error("cipher item changed while stalled");

  // plain_letter is watched only through the take strobe
  a_plain_known: assert property (@(posedge clk) disable iff (rst)
    plain_take |-> !$isunknown(plain_letter))
    else $error("unknown letter accepted");

endmodule

bind three_rotor_letter_cipher trlc_checker u_trlc_checker (
  .clk           (clk),
  .rst           (rst),
  .plain_valid   (plain.valid),
  .plain_ready   (plain.ready),
  .plain_letter  (plain.plain_letter),
  .cipher_valid  (cipher.valid),
  .cipher_ready  (cipher.ready),
  .cipher_letter (cipher.cipher_letter)
);
